// ===== rtl/tsc_pkg.sv =====
// Shared types, character codes and keyword tables for the token splitter.
`timescale 1ns / 1ps

package tsc_pkg;

   localparam int POS_W = 16;
   localparam int LEN_W = 9;
   localparam int NUM_FIXED = 11;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int DEF_MAX_WORD = 256;
   localparam int DEF_LINE_POSITIONS = 65536;

   // Token class codes as seen on the result channel.
   typedef enum logic [3:0] {
      CLS_INT      = 4'd0,
      CLS_STRING   = 4'd1,
      CLS_SEMI     = 4'd2,
      CLS_COLON    = 4'd3,
      CLS_ASSIGN   = 4'd4,
      CLS_LPAREN   = 4'd5,
      CLS_RPAREN   = 4'd6,
      CLS_OPERATOR = 4'd7,
      CLS_LOGICOP  = 4'd8,
      CLS_KEYWORD  = 4'd9,
      CLS_IDENT    = 4'd10,
      CLS_END      = 4'd11,
      CLS_OVERFLOW = 4'd12
   } token_class_type;

   // Positions of the fixed words in the match flag vector.
   localparam int FW_IF    = 0;
   localparam int FW_ELSE  = 1;
   localparam int FW_PRINT = 2;
   localparam int FW_END   = 3;
   localparam int FW_PLUS  = 4;
   localparam int FW_MINUS = 5;
   localparam int FW_STAR  = 6;
   localparam int FW_EQEQ  = 7;
   localparam int FW_NEQ   = 8;
   localparam int FW_GT    = 9;
   localparam int FW_LT    = 10;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQUALS = 8'h3D;

   typedef struct packed {
      token_class_type     cls;
      logic [POS_W-1:0]    start;
      logic [LEN_W-1:0]    length;
      logic                last;
   } result_type;

   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } push_type;

   // Characters of a fixed word, first character in the low byte.
   function automatic logic [39:0] fixed_text(input int unsigned idx);
      logic [39:0] t;
      case (idx)
         FW_IF:    t = 40'h0000006669;
         FW_ELSE:  t = 40'h0065736C65;
         FW_PRINT: t = 40'h746E697270;
         FW_END:   t = 40'h0000646E65;
         FW_PLUS:  t = 40'h000000002B;
         FW_MINUS: t = 40'h000000002D;
         FW_STAR:  t = 40'h000000002A;
         FW_EQEQ:  t = 40'h0000003D3D;
         FW_NEQ:   t = 40'h0000003D21;
         FW_GT:    t = 40'h000000003E;
         FW_LT:    t = 40'h000000003C;
         default:  t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [2:0] fixed_len(input int unsigned idx);
      logic [2:0] n;
      case (idx)
         FW_IF:    n = 3'd2;
         FW_ELSE:  n = 3'd4;
         FW_PRINT: n = 3'd5;
         FW_END:   n = 3'd3;
         FW_EQEQ:  n = 3'd2;
         FW_NEQ:   n = 3'd2;
         default:  n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] fixed_char(input int unsigned idx, input logic [2:0] k);
      logic [39:0] t;
      logic [7:0]  c;
      t = fixed_text(idx);
      case (k)
         3'd0:    c = t[7:0];
         3'd1:    c = t[15:8];
         3'd2:    c = t[23:16];
         3'd3:    c = t[31:24];
         3'd4:    c = t[39:32];
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/tsc_word_tracker.sv =====
// Line and word state: gathers bytes, classifies finished words, forms results.
`timescale 1ns / 1ps

module tsc_word_tracker #(
   parameter int MAX_WORD = tsc_pkg::DEF_MAX_WORD,
   parameter int LINE_POSITIONS = tsc_pkg::DEF_LINE_POSITIONS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          source_byte,
   output tsc_pkg::push_type   push
);
   import tsc_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_POSITIONS - 1);

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [POS_W-1:0]     start_ff, start_in;
   logic [POS_W-1:0]     content_ff, content_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 inq_ff, inq_in;
   logic                 digits_ff, digits_in;
   logic                 fquote_ff, fquote_in;
   logic                 lquote_ff, lquote_in;
   logic                 feq_ff, feq_in;
   logic [NUM_FIXED-1:0] match_ff, match_in;
   logic                 skip_ff, skip_in;

   logic                 is_quote, is_space, is_delim, is_digit;
   logic                 len_zero;
   logic [NUM_FIXED-1:0] full_match, push_match;
   logic [LEN_W-1:0]     push_len;
   logic [POS_W-1:0]     push_start;
   logic                 do_push, do_sep, clear_word;
   result_type           word_res, end_res, ovf_res, delim_res;
   token_class_type      delim_cls;

   assign is_quote = (source_byte == CH_DQUOTE) || (source_byte == CH_SQUOTE);
   assign is_space = (source_byte == CH_SPACE) ||
                     ((source_byte >= CH_TAB) && (source_byte <= CH_CR));
   assign is_delim = (source_byte == CH_SEMI) || (source_byte == CH_COLON) ||
                     (source_byte == CH_LPAREN) || (source_byte == CH_RPAREN);
   assign is_digit = (source_byte >= CH_ZERO) && (source_byte <= CH_NINE);
   assign len_zero = (len_ff == '0);
   assign push_len = len_ff + LEN_W'(1);
   assign push_start = len_zero ? pos_ff : start_ff;

   // A fixed word survives while every byte so far equals its character.
   always_comb begin
      for (int i = 0; i < NUM_FIXED; i++) begin
         full_match[i] = match_ff[i] && (len_ff == LEN_W'(fixed_len(i)));
         push_match[i] = (len_zero || match_ff[i]) &&
                         (len_ff < LEN_W'(fixed_len(i))) &&
                         (fixed_char(i, len_ff[2:0]) == source_byte);
      end
   end

   always_comb begin
      word_res.start = start_ff;
      word_res.length = len_ff;
      word_res.last = 1'b0;
      if (digits_ff) begin
         word_res.cls = CLS_INT;
      end else if (fquote_ff && lquote_ff && (len_ff >= LEN_W'(2))) begin
         word_res.cls = CLS_STRING;
         word_res.start = content_ff;
         word_res.length = len_ff - LEN_W'(2);
      end else if (full_match[FW_EQEQ]) begin
         word_res.cls = CLS_LOGICOP;
      end else if (feq_ff) begin
         word_res.cls = CLS_ASSIGN;
      end else if (full_match[FW_PLUS] || full_match[FW_MINUS] || full_match[FW_STAR]) begin
         word_res.cls = CLS_OPERATOR;
      end else if (full_match[FW_NEQ] || full_match[FW_GT] || full_match[FW_LT]) begin
         word_res.cls = CLS_LOGICOP;
      end else if (full_match[FW_IF] || full_match[FW_ELSE] ||
                   full_match[FW_PRINT] || full_match[FW_END]) begin
         word_res.cls = CLS_KEYWORD;
      end else begin
         word_res.cls = CLS_IDENT;
      end
   end

   always_comb begin
      case (source_byte)
         CH_SEMI:   delim_cls = CLS_SEMI;
         CH_COLON:  delim_cls = CLS_COLON;
         CH_LPAREN: delim_cls = CLS_LPAREN;
         default:   delim_cls = CLS_RPAREN;
      endcase
   end

   assign end_res = '{cls: CLS_END, start: pos_ff, length: '0, last: 1'b1};
   assign ovf_res = '{cls: CLS_OVERFLOW, start: push_start, length: MAX_LEN, last: 1'b1};
   assign delim_res = '{cls: delim_cls, start: pos_ff, length: LEN_W'(1), last: 1'b1};

   assign do_push = accept && (source_byte != CH_NUL) && !skip_ff &&
                    (inq_ff ? !is_delim : !(is_space || is_delim));
   assign do_sep = accept && (source_byte != CH_NUL) && !skip_ff && !inq_ff &&
                   (is_space || is_delim);

   always_comb begin
      pos_in = pos_ff;
      start_in = start_ff;
      content_in = content_ff;
      len_in = len_ff;
      inq_in = inq_ff;
      digits_in = digits_ff;
      fquote_in = fquote_ff;
      lquote_in = lquote_ff;
      feq_in = feq_ff;
      match_in = match_ff;
      skip_in = skip_ff;
      clear_word = 1'b0;
      push = '0;

      if (accept) begin
         if (source_byte == CH_NUL) begin
            if (!skip_ff && !len_zero && !inq_ff) begin
               push.count = 2'd2;
               push.first = word_res;
               push.second = end_res;
            end else begin
               push.count = 2'd1;
               push.first = end_res;
            end
            pos_in = '0;
            skip_in = 1'b0;
            clear_word = 1'b1;
         end else begin
            pos_in = (pos_ff == LAST_POS) ? '0 : pos_ff + POS_W'(1);
         end
      end

      if (do_sep) begin
         if (!len_zero) begin
            clear_word = 1'b1;
            if (is_delim) begin
               push.count = 2'd2;
               push.first = word_res;
               push.second = delim_res;
            end else begin
               push.count = 2'd1;
               push.first = word_res;
               push.first.last = 1'b1;
            end
         end else if (is_delim) begin
            push.count = 2'd1;
            push.first = delim_res;
         end
      end

      if (do_push) begin
         if (push_len == MAX_LEN) begin
            push.count = 2'd1;
            push.first = ovf_res;
            skip_in = 1'b1;
            clear_word = 1'b1;
         end else begin
            start_in = push_start;
            if (len_ff == LEN_W'(1)) begin
               content_in = pos_ff;
            end
            len_in = push_len;
            inq_in = inq_ff ^ is_quote;
            digits_in = (len_zero || digits_ff) && is_digit;
            fquote_in = len_zero ? is_quote : fquote_ff;
            lquote_in = is_quote;
            feq_in = len_zero ? (source_byte == CH_EQUALS) : feq_ff;
            match_in = push_match;
         end
      end

      if (clear_word) begin
         start_in = '0;
         content_in = '0;
         len_in = '0;
         inq_in = 1'b0;
         digits_in = 1'b1;
         fquote_in = 1'b0;
         lquote_in = 1'b0;
         feq_in = 1'b0;
         match_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         start_ff <= '0;
         content_ff <= '0;
         len_ff <= '0;
         inq_ff <= 1'b0;
         digits_ff <= 1'b1;
         fquote_ff <= 1'b0;
         lquote_ff <= 1'b0;
         feq_ff <= 1'b0;
         match_ff <= '1;
         skip_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         start_ff <= start_in;
         content_ff <= content_in;
         len_ff <= len_in;
         inq_ff <= inq_in;
         digits_ff <= digits_in;
         fquote_ff <= fquote_in;
         lquote_ff <= lquote_in;
         feq_ff <= feq_in;
         match_ff <= match_in;
         skip_ff <= skip_in;
      end
   end

endmodule

// ===== rtl/tsc_result_queue.sv =====
// Four-entry result queue that takes up to two results per cycle and gives one while its output is not stalled.
`timescale 1ns / 1ps

module tsc_result_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  tsc_pkg::push_type    push,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_stall,
   output tsc_pkg::result_type  out_head
);
   import tsc_pkg::*;

   result_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop;

   assign out_valid = (count_ff != '0);
   assign out_head = entry_ff[rd_ff];
   assign pop = out_valid && !out_stall;
   // Room is judged on the registered count so the input side never waits on the output.
   assign room = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

   assign wr_in = wr_ff + QPTR_W'(push.count);
   assign rd_in = rd_ff + QPTR_W'(pop);
   assign count_in = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ff + QPTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/token_splitter_classifier_core.sv =====
// Top level of the line tokenizer: byte input channel and token result channel.
`timescale 1ns / 1ps

// Takes one source byte per cycle and gives zero, one or two tokens for it;
// a zero byte closes the line with an end token. Tokens are written into a
// four-entry result queue when the byte is accepted and are offered on the
// rsp channel from its head. The byte input stalls while fewer than two queue
// entries are free, so with a consumer that never stalls a run of single-token
// bytes flows at one byte per cycle, while a byte that yields two tokens can
// stall the input once the queue has filled. No clearing pass follows reset.
module token_splitter_classifier_core #(
   parameter int MAX_WORD = tsc_pkg::DEF_MAX_WORD,
   parameter int LINE_POSITIONS = tsc_pkg::DEF_LINE_POSITIONS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_source_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_class,
   output logic [15:0] rsp_token_start,
   output logic [8:0]  rsp_token_length,
   output logic        rsp_last_of_run
);
   import tsc_pkg::*;

   push_type    push;
   result_type  head;
   logic        room;
   logic        accept;

   assign req_stall = !room;
   assign accept = req_valid && room;

   tsc_word_tracker #(
      .MAX_WORD(MAX_WORD),
      .LINE_POSITIONS(LINE_POSITIONS)
   ) u_tracker (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .source_byte(req_source_byte),
      .push(push)
   );

   tsc_result_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .room(room),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_head(head)
   );

   assign rsp_token_class = head.cls;
   assign rsp_token_start = head.start;
   assign rsp_token_length = head.length;
   assign rsp_last_of_run = head.last;

endmodule

// ===== rtl/tsc_checker.sv =====
// Port-level checks for the tokenizer core, bound to the top level.
`timescale 1ns / 1ps

module tsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_token_class,
   input logic [15:0] rsp_token_start,
   input logic [8:0]  rsp_token_length,
   input logic        rsp_last_of_run
);
   import tsc_pkg::*;

   // A stalled result transaction holds still.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_class) &&
      $stable(rsp_token_start) && $stable(rsp_token_length) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The end token is empty and always closes its byte's run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_class == CLS_END) |-> rsp_last_of_run &&
      (rsp_token_length == '0))
      else $error("malformed end token");

   // Delimiter tokens are one byte and are the last result of their byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_token_class == CLS_SEMI) || (rsp_token_class == CLS_COLON) ||
      (rsp_token_class == CLS_LPAREN) || (rsp_token_class == CLS_RPAREN))
      |-> rsp_last_of_run && (rsp_token_length == 9'd1))
      else $error("malformed delimiter token");

endmodule

bind token_splitter_classifier_core tsc_checker u_checker (.*);
